// File: rtl/max_priority_queue_unit_defines.svh
// Assertion macros used by the priority queue datapath.
// Depends on nothing; included by mpq_datapath, which checks its own logic.
`ifndef MAX_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define MAX_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define MPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define MPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mpq_pkg.sv
// Shared types and constants of the priority queue unit.
// Used by the controller, the datapath and the top level.
`default_nettype none

package mpq_pkg;

    localparam int PRIO_W   = 16;
    localparam int DATA_W   = 32;
    localparam int FILL_W   = 5;
    localparam int STATUS_W = 2;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_POP    = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_POPPED   = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic append;
        logic clear_res;
        logic scan_init;
        logic scan_step;
        logic remove;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic full;
        logic scan_done;
    } t_dp_status;

endpackage

`default_nettype wire

// File: rtl/mpq_ctrl.sv
// Controller of the priority queue unit: request decode and scan sequencing.
// Depends on mpq_pkg; drives the datapath through t_dp_cmd.
`default_nettype none

module mpq_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic                 i_req_type,
    input  mpq_pkg::t_dp_status       i_dp_status,
    output mpq_pkg::t_dp_cmd          o_dp_cmd,
    output logic                      o_valid,
    output mpq_pkg::t_status          o_status
);
    import mpq_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state  r_state;
    logic    r_valid;
    t_status r_status;

    always_comb begin
        o_dp_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_req_type == REQ_INSERT) begin
                        o_dp_cmd.clear_res = 1'b1;
                        o_dp_cmd.append    = !i_dp_status.full;
                    end else if (i_dp_status.empty) begin
                        o_dp_cmd.clear_res = 1'b1;
                    end else begin
                        o_dp_cmd.scan_init = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (i_dp_status.scan_done) begin
                    o_dp_cmd.remove = 1'b1;
                end else begin
                    o_dp_cmd.scan_step = 1'b1;
                end
            end
            default: o_dp_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= 1'b0;
            r_status <= ST_INSERTED;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        if (i_req_type == REQ_INSERT) begin
                            r_valid  <= 1'b1;
                            r_status <= i_dp_status.full ? ST_FULL : ST_INSERTED;
                        end else if (i_dp_status.empty) begin
                            r_valid  <= 1'b1;
                            r_status <= ST_EMPTY;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (i_dp_status.scan_done) begin
                        r_valid  <= 1'b1;
                        r_status <= ST_POPPED;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_status = r_status;

endmodule

`default_nettype wire

// File: rtl/mpq_datapath.sv
// Datapath of the priority queue unit: slot array, rotating max scan, removal.
// Depends on mpq_pkg and max_priority_queue_unit_defines.svh.
`default_nettype none

module mpq_datapath #(
    parameter int DEPTH = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  mpq_pkg::t_dp_cmd                      i_dp_cmd,
    output mpq_pkg::t_dp_status                   o_dp_status,
    input  wire logic [mpq_pkg::PRIO_W-1:0]       i_priority_req,
    input  wire logic signed [mpq_pkg::DATA_W-1:0] i_entry_data,
    output logic [mpq_pkg::PRIO_W-1:0]            o_out_priority,
    output logic signed [mpq_pkg::DATA_W-1:0]     o_out_data,
    output logic [mpq_pkg::FILL_W-1:0]            o_fill_count
);
    import mpq_pkg::*;
    `include "max_priority_queue_unit_defines.svh"

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [PRIO_W-1:0]        r_slot_prio [DEPTH];
    logic signed [DATA_W-1:0] r_slot_data [DEPTH];
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            r_pos;
    logic [IW-1:0]            r_best_idx;
    logic [PRIO_W-1:0]        r_best_prio;
    logic signed [DATA_W-1:0] r_best_data;
    logic [PRIO_W-1:0]        r_res_prio;
    logic signed [DATA_W-1:0] r_res_data;
    logic [CW-1:0]            w_best_pos;
    logic                     w_rotate;

    assign w_best_pos = CW'(r_best_idx);
    assign w_rotate   = i_dp_cmd.scan_init || i_dp_cmd.scan_step;

    // Each scan cycle rotates the live entries down by one, so slot zero
    // presents every entry in arrival order and the array ends up unchanged.
    for (genvar g = 0; g < DEPTH; g++) begin : g_slot
        localparam logic [CW-1:0] POS  = CW'(g);
        localparam logic [CW-1:0] POS1 = CW'(g + 1);

        logic [PRIO_W-1:0]        w_up_prio;
        logic signed [DATA_W-1:0] w_up_data;
        logic [PRIO_W-1:0]        n_slot_prio;
        logic signed [DATA_W-1:0] n_slot_data;

        if (g < DEPTH - 1) begin : g_up
            assign w_up_prio = r_slot_prio[g + 1];
            assign w_up_data = r_slot_data[g + 1];
        end else begin : g_top
            assign w_up_prio = r_slot_prio[g];
            assign w_up_data = r_slot_data[g];
        end

        always_comb begin
            n_slot_prio = r_slot_prio[g];
            n_slot_data = r_slot_data[g];
            priority if (i_dp_cmd.append && (r_count == POS)) begin
                n_slot_prio = i_priority_req;
                n_slot_data = i_entry_data;
            end else if (w_rotate && (POS1 == r_count)) begin
                n_slot_prio = r_slot_prio[0];
                n_slot_data = r_slot_data[0];
            end else if (w_rotate && (POS1 < r_count)) begin
                n_slot_prio = w_up_prio;
                n_slot_data = w_up_data;
            end else if (i_dp_cmd.remove && (POS >= w_best_pos) && (POS1 < r_count)) begin
                n_slot_prio = w_up_prio;
                n_slot_data = w_up_data;
            end
        end

        always_ff @(posedge i_clk) begin
            r_slot_prio[g] <= n_slot_prio;
            r_slot_data[g] <= n_slot_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_dp_cmd.append) begin
            r_count <= r_count + CW'(1);
        end else if (i_dp_cmd.remove) begin
            r_count <= r_count - CW'(1);
        end
    end

    // Strictly greater keeps the earliest entry on equal priorities.
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.scan_init) begin
            r_best_prio <= r_slot_prio[0];
            r_best_data <= r_slot_data[0];
            r_best_idx  <= '0;
            r_pos       <= CW'(1);
        end else if (i_dp_cmd.scan_step) begin
            if (r_slot_prio[0] > r_best_prio) begin
                r_best_prio <= r_slot_prio[0];
                r_best_data <= r_slot_data[0];
                r_best_idx  <= r_pos[IW-1:0];
            end
            r_pos <= r_pos + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.clear_res) begin
            r_res_prio <= '0;
            r_res_data <= '0;
        end else if (i_dp_cmd.remove) begin
            r_res_prio <= r_best_prio;
            r_res_data <= r_best_data;
        end
    end

    assign o_dp_status.empty     = (r_count == '0);
    assign o_dp_status.full      = (r_count == FULL_COUNT);
    assign o_dp_status.scan_done = (r_pos == r_count);
    assign o_out_priority        = r_res_prio;
    assign o_out_data            = r_res_data;
    assign o_fill_count          = FILL_W'(r_count);

    `MPQ_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= FULL_COUNT, "entry count above depth")
    `MPQ_ASSERT_NOW(a_no_append_full, i_clk, i_rst_n, i_dp_cmd.append, r_count != FULL_COUNT, "append while full")
    `MPQ_ASSERT_NEXT(a_remove_count, i_clk, i_rst_n, i_dp_cmd.remove, r_count == $past(r_count) - CW'(1), "remove did not drop count")

endmodule

`default_nettype wire

// File: rtl/max_priority_queue_unit.sv
// Top level of the priority queue unit: controller plus slot datapath.
// Depends on mpq_pkg, mpq_ctrl and mpq_datapath.
//
//   channel   | handshake                  | beat fields
//   ----------+----------------------------+------------------------------------------
//   request   | start & !busy              | i_req_type, i_priority_req, i_entry_data
//   result    | o_valid (one-cycle strobe) | o_status, o_out_priority, o_out_data,
//             |                            | o_fill_count
//
// An insert, and a pop of an empty queue, keeps busy low; the result beat follows
// in the next cycle. A pop of a queue holding entries keeps busy high while the max
// scan walks every entry through slot zero; the removal shift happens when the scan
// is done and the result beat follows.
// Reset is synchronous and clears the entry count; slot contents are not cleared.
// The receiver cannot stall: each result beat is shown for one cycle only.
`default_nettype none

module max_priority_queue_unit #(
    parameter int DEPTH = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              i_req_type,
    input  wire logic [mpq_pkg::PRIO_W-1:0]        i_priority_req,
    input  wire logic signed [mpq_pkg::DATA_W-1:0] i_entry_data,
    output logic                                   o_valid,
    output logic [mpq_pkg::STATUS_W-1:0]           o_status,
    output logic [mpq_pkg::PRIO_W-1:0]             o_out_priority,
    output logic signed [mpq_pkg::DATA_W-1:0]      o_out_data,
    output logic [mpq_pkg::FILL_W-1:0]             o_fill_count
);
    import mpq_pkg::*;

    t_dp_cmd    w_dp_cmd;
    t_dp_status w_dp_status;
    t_status    w_status;

    mpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req_type  (i_req_type),
        .i_dp_status (w_dp_status),
        .o_dp_cmd    (w_dp_cmd),
        .o_valid     (o_valid),
        .o_status    (w_status)
    );

    mpq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_dp_cmd       (w_dp_cmd),
        .o_dp_status    (w_dp_status),
        .i_priority_req (i_priority_req),
        .i_entry_data   (i_entry_data),
        .o_out_priority (o_out_priority),
        .o_out_data     (o_out_data),
        .o_fill_count   (o_fill_count)
    );

    assign o_status = w_status;

endmodule

`default_nettype wire

// File: dv/max_priority_queue_unit_tb.sv
// Self-checking testbench for max_priority_queue_unit: inserts and pops with random gaps.
// Needs mpq_pkg and the RTL of the unit; a behavioral queue predicts every result beat.
`timescale 1ns / 1ps

module max_priority_queue_unit_tb;
    import mpq_pkg::*;

    localparam int QUEUE_DEPTH    = 16;
    localparam int RANDOM_ITEMS   = 1000;
    localparam int IDLE_LIMIT     = 2000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int REPORT_LIMIT   = 10;

    typedef struct {
        logic                     kind;
        logic [PRIO_W-1:0]        prio;
        logic signed [DATA_W-1:0] data;
        int unsigned              gap;
        bit                       drain;
    } t_request;

    typedef struct {
        t_status                  status;
        logic [PRIO_W-1:0]        prio;
        logic signed [DATA_W-1:0] data;
        logic [FILL_W-1:0]        fill;
    } t_response;

    logic                     i_clk          = 1'b0;
    logic                     i_rst_n        = 1'b0;
    logic                     start          = 1'b0;
    logic                     i_req_type     = REQ_INSERT;
    logic [PRIO_W-1:0]        i_priority_req = '0;
    logic signed [DATA_W-1:0] i_entry_data   = '0;
    logic                     busy;
    logic                     o_valid;
    logic [STATUS_W-1:0]      o_status;
    logic [PRIO_W-1:0]        o_out_priority;
    logic signed [DATA_W-1:0] o_out_data;
    logic [FILL_W-1:0]        o_fill_count;

    // Contents of the modeled queue, kept in arrival order.
    logic [PRIO_W-1:0]        held_prio [QUEUE_DEPTH];
    logic signed [DATA_W-1:0] held_data [QUEUE_DEPTH];
    int                       held_count = 0;

    t_request  request_backlog[$];
    t_request  in_flight;
    t_response pending_responses[$];
    int unsigned gap_count = 0;

    int mismatch_count = 0;
    int beats_sent     = 0;
    int inserted_seen  = 0;
    int dropped_seen   = 0;
    int popped_seen    = 0;
    int empty_seen     = 0;
    int idle_cycles    = 0;

    max_priority_queue_unit #(
        .DEPTH(QUEUE_DEPTH)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_priority_req (i_priority_req),
        .i_entry_data   (i_entry_data),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_out_priority (o_out_priority),
        .o_out_data     (o_out_data),
        .o_fill_count   (o_fill_count)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic void queue_request(logic kind, logic [PRIO_W-1:0] prio,
                                          logic [DATA_W-1:0] data, int unsigned gap,
                                          bit drain);
        t_request rq;
        rq.kind  = kind;
        rq.prio  = prio;
        rq.data  = data;
        rq.gap   = gap;
        rq.drain = drain;
        request_backlog.push_back(rq);
    endfunction

    function automatic void note_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endfunction

    // Applies one request to the modeled queue and returns the beat it should produce.
    task automatic predict_queue_response(input t_request rq, output t_response rsp);
        int best;
        rsp.status = ST_INSERTED;
        rsp.prio   = '0;
        rsp.data   = '0;
        if (rq.kind == REQ_INSERT) begin
            if (held_count >= QUEUE_DEPTH) begin
                rsp.status = ST_FULL;
            end else begin
                held_prio[held_count] = rq.prio;
                held_data[held_count] = rq.data;
                held_count++;
            end
        end else if (held_count == 0) begin
            rsp.status = ST_EMPTY;
        end else begin
            // Strict greater-than keeps the earliest entry among equal priorities.
            best = 0;
            for (int i = 1; i < held_count; i++) begin
                if (held_prio[i] > held_prio[best]) begin
                    best = i;
                end
            end
            rsp.status = ST_POPPED;
            rsp.prio   = held_prio[best];
            rsp.data   = held_data[best];
            for (int i = best; i + 1 < held_count; i++) begin
                held_prio[i] = held_prio[i + 1];
                held_data[i] = held_data[i + 1];
            end
            held_count--;
        end
        rsp.fill = held_count[FILL_W-1:0];
    endtask

    // Request driver: one beat per start & !busy edge, gaps drawn per item.
    always @(posedge i_clk) begin : drive_requests
        t_response rsp;
        t_request  nxt;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                predict_queue_response(in_flight, rsp);
                pending_responses.push_back(rsp);
                beats_sent++;
            end
            if (!start || !busy) begin
                if (request_backlog.size() == 0) begin
                    start <= 1'b0;
                end else begin
                    nxt = request_backlog[0];
                    if (gap_count < nxt.gap) begin
                        gap_count++;
                        start <= 1'b0;
                    end else if (nxt.drain && pending_responses.size() != 0) begin
                        start <= 1'b0;
                    end else begin
                        in_flight = request_backlog.pop_front();
                        gap_count = 0;
                        start          <= 1'b1;
                        i_req_type     <= in_flight.kind;
                        i_priority_req <= in_flight.prio;
                        i_entry_data   <= in_flight.data;
                    end
                end
            end
        end
    end

    // Result monitor: each strobed beat is checked against the oldest expectation.
    always @(posedge i_clk) begin : check_responses
        t_response want;
        if (i_rst_n && o_valid) begin
            case (o_status)
                ST_INSERTED: inserted_seen++;
                ST_FULL:     dropped_seen++;
                ST_POPPED:   popped_seen++;
                default:     empty_seen++;
            endcase
            if (pending_responses.size() == 0) begin
                note_mismatch($sformatf("unexpected beat status=%0d prio=%h data=%h fill=%0d",
                                        o_status, o_out_priority, o_out_data, o_fill_count));
            end else begin
                want = pending_responses.pop_front();
                if (o_status !== want.status || o_out_priority !== want.prio ||
                    o_out_data !== want.data || o_fill_count !== want.fill) begin
                    note_mismatch($sformatf(
                        "expected status=%0d prio=%h data=%h fill=%0d, got %0d %h %h %0d",
                        want.status, want.prio, want.data, want.fill,
                        o_status, o_out_priority, o_out_data, o_fill_count));
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (i_rst_n) begin
            if ((start && !busy) || o_valid) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("Watchdog expired after %0d idle cycles", idle_cycles);
                $display("TEST FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        int          block_len;
        int          insert_pct;
        int          prio_mode;
        int          idle_mode;
        int          made;
        logic [PRIO_W-1:0] prio;
        int unsigned gap;

        // Directed part: pop of an empty queue, extremes, ties, fill to full, drop, pops.
        queue_request(REQ_POP,    16'hFFFF, 32'hFFFF_FFFF, 0, 1'b0);
        queue_request(REQ_INSERT, 16'h0000, 32'h8000_0000, 0, 1'b0);
        queue_request(REQ_INSERT, 16'hFFFF, 32'h7FFF_FFFF, 1, 1'b0);
        queue_request(REQ_INSERT, 16'h8000, 32'h0000_0000, 0, 1'b0);
        queue_request(REQ_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 0, 1'b0);
        queue_request(REQ_INSERT, 16'h0001, 32'h0000_0001, 3, 1'b0);
        queue_request(REQ_INSERT, 16'h7FFF, 32'h5555_5555, 0, 1'b0);
        queue_request(REQ_INSERT, 16'h8000, 32'hAAAA_AAAA, 0, 1'b0);
        queue_request(REQ_INSERT, 16'h0000, 32'h1234_5678, 0, 1'b0);
        for (int i = 0; i < 8; i++) begin
            queue_request(REQ_INSERT, 16'h8000 + i[1:0], $urandom, i % 3, 1'b0);
        end
        queue_request(REQ_INSERT, 16'hFFFF, 32'hDEAD_BEEF, 0, 1'b0);
        for (int i = 0; i < 6; i++) begin
            queue_request(REQ_POP, PRIO_W'($urandom), $urandom, (i == 2) ? 5 : 0, i == 4);
        end

        // Random part: blocks that lean toward filling, churning or draining the queue.
        made = 0;
        while (made < RANDOM_ITEMS) begin
            block_len  = $urandom_range(60, 20);
            case ($urandom_range(2))
                0:       insert_pct = 85;
                1:       insert_pct = 50;
                default: insert_pct = 15;
            endcase
            prio_mode = $urandom_range(2);
            idle_mode = $urandom_range(2);
            for (int i = 0; i < block_len; i++) begin
                case (prio_mode)
                    0: prio = PRIO_W'($urandom);
                    1: prio = PRIO_W'($urandom_range(3));
                    default: begin
                        case ($urandom_range(3))
                            0:       prio = 16'h0000;
                            1:       prio = 16'hFFFF;
                            2:       prio = 16'h0001;
                            default: prio = 16'hFFFE;
                        endcase
                    end
                endcase
                case (idle_mode)
                    0:       gap = 0;
                    1:       gap = $urandom_range(16);
                    default: gap = $urandom_range(2);
                endcase
                queue_request(($urandom_range(99) < insert_pct) ? REQ_INSERT : REQ_POP,
                              prio, $urandom, gap, $urandom_range(99) == 0);
            end
            made += block_len;
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(posedge i_clk);
        end while (request_backlog.size() != 0 || start || pending_responses.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests: %0d inserted, %0d dropped while full,",
                 beats_sent, inserted_seen, dropped_seen);
        $display("%0d popped, %0d pops of an empty queue; %0d mismatches.",
                 popped_seen, empty_seen, mismatch_count);
        if (mismatch_count == 0 && pending_responses.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
